// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/csb_pkg.sv =====
// ----------------------------------------------------------------------------
// csb_pkg
// Types and constants for the clipped sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

  localparam int KIND_W    = 2;
  localparam int CODE_W    = 8;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 1;

  // A sprite origin plus a cursor position, one bit of headroom for the sign.
  localparam int POS_W  = COORD_W + 1;
  // Row times frame width plus column, before the store limit is applied.
  localparam int PROD_W = COORD_W + DIM_W;

  localparam int STORE_DEPTH_DEF   = 4096;
  localparam int MAX_DIMENSION_DEF = 64;

  localparam logic [DIM_W-1:0] FRAME_DIM_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RUN,
    ST_CLEAR,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic        [KIND_W-1:0]  kind;
    logic        [CODE_W-1:0]  pixel_code;
    logic signed [COORD_W-1:0] position_x;
    logic signed [COORD_W-1:0] position_y;
    logic        [DIM_W-1:0]   sprite_width;
    logic        [DIM_W-1:0]   sprite_height;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_value;
    logic              out_of_range;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/clipped_sprite_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// clipped_sprite_blitter_unit
// Byte-per-cell frame store with clipped, transparent sprite writes, cell
// reads and an area clear.
// ----------------------------------------------------------------------------
// Each item first lands in an input register and is executed from there
// against a single-port frame memory with a registered read. Sprite pixels,
// whether written, clipped or transparent, and unused kinds go through at one
// item per cycle while no clear is under way and no read is held in the input
// register. A read is issued only once the result register is free and no
// earlier read is pending; its data pass through the memory read register into
// the result register. A clear walks the memory one cell per cycle over width
// times height cells (at most STORE_DEPTH), and its zero result is loaded once
// the walk ends and the result register is free. After reset a clearing pass
// over all STORE_DEPTH cells zeroes the whole store, and the first item is
// taken after the init state; configuration writes are taken at all times.
`default_nettype none

`include "assert_macros.svh"

module clipped_sprite_blitter_unit #(
  parameter int STORE_DEPTH   = csb_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DIMENSION = csb_pkg::MAX_DIMENSION_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             item_valid,
  output logic                            item_ready,
  input  csb_pkg::item_t                  item,
  output logic                            result_valid,
  input  wire                             result_ready,
  output csb_pkg::result_t                result,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [csb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [csb_pkg::DIM_W-1:0]       cfg_data
);

  localparam int DIM_W   = csb_pkg::DIM_W;
  localparam int POS_W   = csb_pkg::POS_W;
  localparam int PROD_W  = csb_pkg::PROD_W;
  localparam int CODE_W  = csb_pkg::CODE_W;
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int MAX_LIM = (MAX_DIMENSION < DIM_MAX) ? MAX_DIMENSION : DIM_MAX;
  localparam int CUR_W   = $clog2(MAX_LIM);
  localparam int AW      = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int LIM_W   = (CNT_W > PROD_W) ? CNT_W : PROD_W;
  localparam int CMP_W   = DIM_W + 1;

  localparam logic [DIM_W-1:0] MAX_V = DIM_W'(MAX_LIM);

  csb_pkg::state_t state, state_next;

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic [CUR_W-1:0]  cursor_col;
  logic [CUR_W-1:0]  cursor_row;

  logic                        s1_valid;
  logic [csb_pkg::KIND_W-1:0]  s1_kind;
  logic [CODE_W-1:0]           s1_code;
  logic signed [POS_W-1:0]     s1_col;
  logic signed [POS_W-1:0]     s1_row;

  logic [CNT_W-1:0]  clr_cnt;
  logic [CNT_W-1:0]  clr_end;
  logic              rd_pending;
  logic              rd_oor;

  logic [CODE_W-1:0] mem [STORE_DEPTH];
  logic [CODE_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;

  logic s1_fire;
  logic rd_issue;
  logic ack_load;
  logic slot_free;
  logic clr_busy;
  logic item_xfer;

  logic [DIM_W-1:0]  w_eff, h_eff, sw_eff, sh_eff;
  logic [CUR_W:0]    col_inc, row_inc;
  logic              col_wrap, row_wrap;
  logic              col_ok, row_ok, cell_ok;
  logic [POS_W-2:0]  col_u, row_u;
  logic [PROD_W-1:0] addr_full;
  logic [PROD_W-1:0] area;
  logic [CNT_W-1:0]  area_lim;
  logic [AW-1:0]     cell_addr;
  logic signed [POS_W-1:0] tgt_col, tgt_row;

  assign cfg_ready = 1'b1;

  assign w_eff  = (frame_width > MAX_V) ? MAX_V : frame_width;
  assign h_eff  = (frame_height > MAX_V) ? MAX_V : frame_height;
  assign sw_eff = (item.sprite_width == '0) ? DIM_W'(1) :
                  ((item.sprite_width > MAX_V) ? MAX_V : item.sprite_width);
  assign sh_eff = (item.sprite_height == '0) ? DIM_W'(1) :
                  ((item.sprite_height > MAX_V) ? MAX_V : item.sprite_height);

  assign col_inc  = {1'b0, cursor_col} + (CUR_W + 1)'(1);
  assign row_inc  = {1'b0, cursor_row} + (CUR_W + 1)'(1);
  assign col_wrap = CMP_W'(col_inc) >= CMP_W'(sw_eff);
  assign row_wrap = CMP_W'(row_inc) >= CMP_W'(sh_eff);

  assign tgt_col = signed'(POS_W'(item.position_x)) + signed'(POS_W'(cursor_col));
  assign tgt_row = signed'(POS_W'(item.position_y)) + signed'(POS_W'(cursor_row));

  assign item_xfer = item_valid && item_ready;
  assign item_ready = (state != csb_pkg::ST_INIT) && (!s1_valid || s1_fire);

  assign col_u     = s1_col[POS_W-2:0];
  assign row_u     = s1_row[POS_W-2:0];
  assign col_ok    = !s1_col[POS_W-1] && (col_u < (POS_W - 1)'(w_eff));
  assign row_ok    = !s1_row[POS_W-1] && (row_u < (POS_W - 1)'(h_eff));
  assign addr_full = PROD_W'(row_u) * PROD_W'(w_eff) + PROD_W'(col_u);
  assign cell_ok   = col_ok && row_ok && (LIM_W'(addr_full) < LIM_W'(STORE_DEPTH));
  assign cell_addr = AW'(addr_full);

  assign area     = PROD_W'(w_eff) * PROD_W'(h_eff);
  assign area_lim = (LIM_W'(area) > LIM_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH)
                                                         : CNT_W'(area);

  assign clr_busy  = clr_cnt < clr_end;
  assign slot_free = !rd_pending && (!result_valid || result_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      csb_pkg::ST_INIT: begin
        if (!clr_busy) state_next = csb_pkg::ST_RUN;
      end
      csb_pkg::ST_RUN: begin
        if (s1_fire && s1_kind == csb_pkg::KIND_CLEAR) state_next = csb_pkg::ST_CLEAR;
      end
      csb_pkg::ST_CLEAR: begin
        if (!clr_busy) state_next = csb_pkg::ST_ACK;
      end
      csb_pkg::ST_ACK: begin
        if (ack_load) state_next = csb_pkg::ST_RUN;
      end
      default: state_next = csb_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt[AW-1:0];
    mem_wdata = '0;
    s1_fire   = 1'b0;
    rd_issue  = 1'b0;
    ack_load  = 1'b0;
    unique case (state)
      csb_pkg::ST_INIT, csb_pkg::ST_CLEAR: begin
        mem_we = clr_busy;
      end
      csb_pkg::ST_RUN: begin
        s1_fire  = s1_valid && (s1_kind != csb_pkg::KIND_READ || slot_free);
        rd_issue = s1_fire && s1_kind == csb_pkg::KIND_READ;
        if (s1_fire && s1_kind == csb_pkg::KIND_PIXEL && s1_code != '0 && cell_ok) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr;
          mem_wdata = s1_code;
        end
      end
      csb_pkg::ST_ACK: begin
        ack_load = slot_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_issue) mem_rdata <= mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csb_pkg::ST_INIT;
      frame_width  <= csb_pkg::FRAME_DIM_RESET;
      frame_height <= csb_pkg::FRAME_DIM_RESET;
      cursor_col   <= '0;
      cursor_row   <= '0;
      s1_valid     <= 1'b0;
      clr_cnt      <= '0;
      clr_end      <= CNT_W'(STORE_DEPTH);
      rd_pending   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == csb_pkg::REG_FRAME_WIDTH) frame_width <= cfg_data;
        if (cfg_index == csb_pkg::REG_FRAME_HEIGHT) frame_height <= cfg_data;
      end

      if (item_xfer && item.kind == csb_pkg::KIND_PIXEL) begin
        if (col_wrap) begin
          cursor_col <= '0;
          cursor_row <= row_wrap ? '0 : row_inc[CUR_W-1:0];
        end else begin
          cursor_col <= col_inc[CUR_W-1:0];
        end
      end

      if (item_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire && s1_kind == csb_pkg::KIND_CLEAR) begin
        clr_cnt <= '0;
        clr_end <= area_lim;
      end else if (mem_we && state != csb_pkg::ST_RUN) begin
        clr_cnt <= clr_cnt + CNT_W'(1);
      end

      rd_pending <= rd_issue;

      if (rd_pending || ack_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      s1_kind <= item.kind;
      s1_code <= item.pixel_code;
      if (item.kind == csb_pkg::KIND_PIXEL) begin
        s1_col <= tgt_col;
        s1_row <= tgt_row;
      end else begin
        s1_col <= signed'(POS_W'(item.position_x));
        s1_row <= signed'(POS_W'(item.position_y));
      end
    end
    if (rd_issue) rd_oor <= !cell_ok;
    if (rd_pending) begin
      result.cell_value   <= rd_oor ? '0 : mem_rdata;
      result.out_of_range <= rd_oor;
    end else if (ack_load) begin
      result.cell_value   <= '0;
      result.out_of_range <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_slot_free_on_read, clk, rst, rd_pending, !result_valid,
                  "read data has no free result register")
  `ASSERT_IMPLIES(a_oor_reads_zero, clk, rst, result_valid && result.out_of_range,
                  result.cell_value == '0, "out-of-range result carries a value")
  `ASSERT_NEXT(a_ack_delivered, clk, rst, state == csb_pkg::ST_ACK && ack_load,
               result_valid && !result.out_of_range && result.cell_value == '0,
               "clear acknowledgement lost")
  `ASSERT_IMPLIES(a_cursor_bounds, clk, rst, 1'b1,
                  DIM_W'(cursor_col) < MAX_V && DIM_W'(cursor_row) < MAX_V,
                  "cursor beyond the largest sprite")

endmodule

`default_nettype wire

// ===== verif/clipped_sprite_blitter_unit_test.sv =====
// ----------------------------------------------------------------------------
// clipped_sprite_blitter_unit_test
// Self-checking bench for the sprite blitter. A scoreboard keeps its own copy
// of the frame store, the sprite cursor and the frame size. It predicts every
// cell read and clear acknowledgement and checks them in order. Directed items
// come first, then random sprites, reads, clears and noise over a series of
// frame sizes, with random idling on both the item and result channels.
// ----------------------------------------------------------------------------
module clipped_sprite_blitter_unit_test;
  import csb_pkg::*;

  localparam int STORE_CELLS     = STORE_DEPTH_DEF;
  localparam int DIM_LIMIT       = MAX_DIMENSION_DEF;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 20000;
  localparam int SIDE_ITEM       = 0;
  localparam int SIDE_RESULT     = 1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  class blit_scoreboard;
    logic [CODE_W-1:0] cells [STORE_CELLS];
    int cursor_col;
    int cursor_row;
    int frame_w;
    int frame_h;
    result_t awaited_results [$];
    int mismatches;
    int reads_seen;
    int clears_seen;
    int results_checked;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cursor_col = 0;
      cursor_row = 0;
      frame_w = FRAME_DIM_RESET;
      frame_h = FRAME_DIM_RESET;
    endfunction

    function int clamp_dim(int v, int lo);
      if (v < lo) return lo;
      if (v > DIM_LIMIT) return DIM_LIMIT;
      return v;
    endfunction

    function bit cell_index(int col, int row, output int addr);
      int w;
      int h;
      w = clamp_dim(frame_w, 0);
      h = clamp_dim(frame_h, 0);
      addr = 0;
      if (col < 0 || row < 0 || col >= w || row >= h) return 1'b0;
      addr = row * w + col;
      return addr < STORE_CELLS;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) frame_w = val;
      else if (idx == REG_FRAME_HEIGHT) frame_h = val;
    endfunction

    function void accept_item(item_t it);
      int col;
      int row;
      int addr;
      int span;
      int sw;
      int sh;
      result_t want;
      sw = clamp_dim(it.sprite_width, 1);
      sh = clamp_dim(it.sprite_height, 1);
      case (it.kind)
        KIND_PIXEL: begin
          col = $signed(it.position_x) + cursor_col;
          row = $signed(it.position_y) + cursor_row;
          if (it.pixel_code != '0 && cell_index(col, row, addr)) cells[addr] = it.pixel_code;
          cursor_col++;
          if (cursor_col >= sw) begin
            cursor_col = 0;
            cursor_row++;
            if (cursor_row >= sh) cursor_row = 0;
          end
        end
        KIND_READ: begin
          if (cell_index($signed(it.position_x), $signed(it.position_y), addr)) begin
            want.cell_value = cells[addr];
            want.out_of_range = 1'b0;
          end else begin
            want.cell_value = '0;
            want.out_of_range = 1'b1;
          end
          awaited_results.push_back(want);
          reads_seen++;
        end
        KIND_CLEAR: begin
          span = clamp_dim(frame_w, 0) * clamp_dim(frame_h, 0);
          if (span > STORE_CELLS) span = STORE_CELLS;
          for (int i = 0; i < span; i++) cells[i] = '0;
          want = '0;
          awaited_results.push_back(want);
          clears_seen++;
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: cell_value=%0d out_of_range=%0b",
                         got.cell_value, got.out_of_range));
        return;
      end
      want = awaited_results.pop_front();
      if (got.cell_value !== want.cell_value)
        report($sformatf("cell_value %0d, expected %0d", got.cell_value, want.cell_value));
      if (got.out_of_range !== want.out_of_range)
        report($sformatf("out_of_range %0b, expected %0b", got.out_of_range,
                         want.out_of_range));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  blit_scoreboard tracker;
  int items_sent = 0;
  int calm_left [2];
  int quiet_cycles = 0;

  clipped_sprite_blitter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(19) == 0) calm_left[side] = 10 + $urandom_range(30);
    return $urandom_range(10);
  endfunction

  function automatic item_t make_item(logic [KIND_W-1:0] k, int code, int x, int y,
                                      int w, int h);
    item_t it;
    it.kind          = k;
    it.pixel_code    = code[CODE_W-1:0];
    it.position_x    = x[COORD_W-1:0];
    it.position_y    = y[COORD_W-1:0];
    it.sprite_width  = w[DIM_W-1:0];
    it.sprite_height = h[DIM_W-1:0];
    return it;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(255)) - 128;
  endfunction

  function automatic int pixel_draw();
    if ($urandom_range(3) == 0) return 0;
    return $urandom_range(255);
  endfunction

  function automatic int place_coord(int size, int span);
    if ($urandom_range(9) == 0) return any_coord();
    return int'($urandom_range(span + size + 2)) - size - 1;
  endfunction

  function automatic int read_coord(int span);
    if ($urandom_range(4) == 0) return any_coord();
    return int'($urandom_range(span + 3)) - 2;
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = draw_wait(SIDE_ITEM);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.accept_item(it);
    if (it.kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_side
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(SIDE_RESULT);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_result(result);
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAIL clipped_sprite_blitter_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    int fw;
    int fh;
    int fwc;
    int fhc;
    int target;
    int pick;
    int sw;
    int sh;
    int sprite_x;
    int sprite_y;
    int count;
    int k;
    tracker = new();
    sw = 1;
    sh = 1;
    sprite_x = 0;
    sprite_y = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset frame size of 64 by 64.
    send_item(make_item(KIND_PIXEL, 255, 0, 0, 2, 2));
    send_item(make_item(KIND_PIXEL, 0, 0, 0, 2, 2));
    send_item(make_item(KIND_PIXEL, 1, 0, 0, 2, 2));
    send_item(make_item(KIND_PIXEL, 128, 0, 0, 2, 2));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 1, 0, 0, 0));
    send_item(make_item(KIND_READ, 255, 1, 1, 127, 127));
    send_item(make_item(KIND_PIXEL, 7, -128, -128, 1, 1));
    send_item(make_item(KIND_PIXEL, 9, 127, 127, 1, 1));
    for (k = 0; k < 3; k++) send_item(make_item(KIND_PIXEL, 11 + k, 62, 63, 3, 1));
    send_item(make_item(KIND_READ, 0, 63, 63, 0, 0));
    send_item(make_item(KIND_READ, 0, 64, 63, 0, 0));
    send_item(make_item(KIND_READ, 0, -1, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 127, -128, 0, 0));
    send_item(make_item(KIND_READ, 0, -128, 127, 0, 0));
    // A zero sprite size behaves as one cell.
    send_item(make_item(KIND_PIXEL, 21, 5, 5, 0, 0));
    send_item(make_item(KIND_READ, 0, 5, 5, 0, 0));
    // The sprite size shrinks while the cursor is beyond the new size.
    send_item(make_item(KIND_PIXEL, 30, 10, 10, 4, 4));
    send_item(make_item(KIND_PIXEL, 31, 10, 10, 4, 4));
    send_item(make_item(KIND_PIXEL, 32, 10, 10, 1, 1));
    send_item(make_item(KIND_READ, 0, 12, 10, 0, 0));
    send_item(make_item(KIND_UNUSED, 255, -1, -1, 127, 127));
    send_item(make_item(KIND_CLEAR, 255, 127, -128, 127, 127));
    send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
    send_item(make_item(KIND_READ, 0, 63, 63, 0, 0));

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin fw = 1;   fh = 1;   end
        1: begin fw = 0;   fh = 12;  end
        2: begin fw = 12;  fh = 0;   end
        3: begin fw = 127; fh = 127; end
        4: begin fw = 8;   fh = 8;   end
        5: begin fw = 20;  fh = 5;   end
        6: begin fw = 3;   fh = 40;  end
        7: begin fw = 64;  fh = 1;   end
        8: begin fw = 64;  fh = 64;  end
        default: begin
          fw = $urandom_range(127);
          fh = $urandom_range(127);
        end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data <= fw[DIM_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_register(REG_FRAME_WIDTH, fw[DIM_W-1:0]);
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data <= fh[DIM_W-1:0];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.set_register(REG_FRAME_HEIGHT, fh[DIM_W-1:0]);
      cfg_valid <= 1'b0;

      fwc = tracker.clamp_dim(fw, 0);
      fhc = tracker.clamp_dim(fh, 0);
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          sw = 1 + $urandom_range(7);
          sh = 1 + $urandom_range(7);
          if ($urandom_range(7) == 0) begin
            sw = 1 + $urandom_range(15);
            sh = 1 + $urandom_range(3);
          end
          // A single one-cell pixel brings the cursor back to the sprite origin.
          if (tracker.cursor_col != 0 || tracker.cursor_row != 0)
            send_item(make_item(KIND_PIXEL, pixel_draw(), any_coord(), any_coord(), 1, 1));
          sprite_x = place_coord(sw, fwc);
          sprite_y = place_coord(sh, fhc);
          count = sw * sh;
          if ($urandom_range(9) == 0) count = 1 + $urandom_range(count - 1);
          for (k = 0; k < count; k++)
            send_item(make_item(KIND_PIXEL, pixel_draw(), sprite_x, sprite_y, sw, sh));
        end else if (pick < 80) begin
          count = 1 + $urandom_range(3);
          for (k = 0; k < count; k++) begin
            if ($urandom_range(1) == 0)
              send_item(make_item(KIND_READ, $urandom_range(255),
                                  sprite_x + int'($urandom_range(sw - 1)),
                                  sprite_y + int'($urandom_range(sh - 1)),
                                  $urandom_range(127), $urandom_range(127)));
            else
              send_item(make_item(KIND_READ, $urandom_range(255), read_coord(fwc),
                                  read_coord(fhc), $urandom_range(127),
                                  $urandom_range(127)));
          end
        end else if (pick < 95) begin
          if ($urandom_range(2) == 0) begin
            // A row wider than the largest sprite, so the cursor wraps at the limit.
            sw = 65 + $urandom_range(62);
            sh = 1 + $urandom_range(1);
            sprite_x = int'($urandom_range(8)) - 4;
            sprite_y = place_coord(sh, fhc);
            for (k = 0; k < 65; k++)
              send_item(make_item(KIND_PIXEL, pixel_draw(), sprite_x, sprite_y, sw, sh));
          end else begin
            count = 1 + $urandom_range(5);
            for (k = 0; k < count; k++)
              send_item(make_item(KIND_PIXEL, $urandom_range(255), any_coord(),
                                  any_coord(), $urandom_range(127), $urandom_range(127)));
          end
        end else if (pick < 98) begin
          send_item(make_item(KIND_CLEAR, $urandom_range(255), any_coord(), any_coord(),
                              $urandom_range(127), $urandom_range(127)));
        end else begin
          send_item(make_item(KIND_UNUSED, $urandom_range(255), any_coord(), any_coord(),
                              $urandom_range(127), $urandom_range(127)));
        end
      end
    end

    settle();
    $display("Run covered %0d items over %0d frame sizes, empty and oversized included.",
             items_sent, PHASES + 1);
    $display("Checked %0d results: %0d cell reads and %0d clear acknowledgements.",
             tracker.results_checked, tracker.reads_seen, tracker.clears_seen);
    if (tracker.mismatches == 0) begin
      $display("PASS clipped_sprite_blitter_unit");
    end else begin
      $display("FAIL clipped_sprite_blitter_unit");
    end
    $finish;
  end

endmodule
